[rtl/core/aise_pkg.sv]
// ----------------------------------------------------------------------------
// aise_pkg
// Shared types and constants for the array insert and statistics engine.
// ----------------------------------------------------------------------------
package aise_pkg;

  localparam int unsigned Capacity  = 128;
  localparam int unsigned WordWidth = 32;
  localparam int unsigned IdxW      = $clog2(Capacity);
  localparam int unsigned CntW      = $clog2(Capacity + 1);
  localparam int unsigned MainW     = 40;

  typedef enum logic [2:0] {
    REQ_APPEND = 3'd0,
    REQ_INSERT = 3'd1,
    REQ_READ   = 3'd2,
    REQ_EVEN   = 3'd3,
    REQ_MINMAX = 3'd4,
    REQ_PRIME  = 3'd5,
    REQ_COUNT  = 3'd6
  } req_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  position;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [39:0] result_main;
    logic [31:0] result_min;
    logic [7:0]  fill_count;
  } rsp_t;

  // prime test handshake between sequencer and trial divider
  typedef struct packed {
    logic                 start;
    logic [WordWidth-1:0] word;
  } prime_req_t;

  typedef struct packed {
    logic done;
    logic prime;
  } prime_rsp_t;

endpackage

[rtl/core/aise_if.sv]
// ----------------------------------------------------------------------------
// aise_req_if / aise_rsp_if
// Valid/ready channels for requests and responses.
// ----------------------------------------------------------------------------
interface aise_req_if;
  logic             valid;
  logic             ready;
  aise_pkg::req_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface aise_rsp_if;
  logic             valid;
  logic             ready;
  aise_pkg::rsp_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/aise_ram.sv]
// ----------------------------------------------------------------------------
// aise_ram
// Single-port entry store, one write or one registered read per cycle.
// ----------------------------------------------------------------------------
module aise_ram (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [aise_pkg::IdxW-1:0]               addr_i,
  input  logic [aise_pkg::WordWidth-1:0]          wdata_i,
  output logic [aise_pkg::WordWidth-1:0]          rdata_o
);
  import aise_pkg::*;

  logic [WordWidth-1:0] mem [Capacity];

  // write or read, read data registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

[rtl/core/aise_prime.sv]
// ----------------------------------------------------------------------------
// aise_prime
// Trial divider: tests odd divisors j while j*j <= x, one remainder bit per
// cycle through a restoring divider.
// ----------------------------------------------------------------------------
module aise_prime (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  aise_pkg::prime_req_t   req_i,
  output aise_pkg::prime_rsp_t   rsp_o
);
  import aise_pkg::*;

  localparam int unsigned BitCntW = $clog2(WordWidth + 1);

  typedef enum logic [2:0] {S_IDLE, S_CHECK, S_DIV, S_NEXT, S_DONE} state_e;

  state_e               state_q;
  logic [WordWidth-1:0] x_q;
  logic [WordWidth-1:0] j_q;
  logic [WordWidth-1:0] quo_q;
  logic [WordWidth:0]   rem_q;
  logic [BitCntW-1:0]   bit_q;
  logic [2*WordWidth-1:0] sq_q;
  logic                 prime_q;
  logic                 done_q;

  logic [WordWidth:0]   rem_sh;
  logic [WordWidth:0]   rem_sub;

  // one restoring division step
  assign rem_sh  = {rem_q[WordWidth-1:0], quo_q[WordWidth-1]};
  assign rem_sub = rem_sh - {1'b0, j_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      prime_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (req_i.start) begin
            x_q <= req_i.word;
            j_q <= WordWidth'(3);
            sq_q <= (2*WordWidth)'(9);
            if (req_i.word[WordWidth-1] || req_i.word < WordWidth'(2)) begin
              prime_q <= 1'b0;
              state_q <= S_DONE;
            end else if (!req_i.word[0]) begin
              prime_q <= (req_i.word == WordWidth'(2));
              state_q <= S_DONE;
            end else begin
              prime_q <= 1'b1;
              state_q <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (sq_q > {{WordWidth{1'b0}}, x_q}) begin
            state_q <= S_DONE;
          end else begin
            quo_q   <= x_q;
            rem_q   <= '0;
            bit_q   <= BitCntW'(WordWidth);
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (!rem_sub[WordWidth]) begin
            rem_q <= rem_sub;
          end else begin
            rem_q <= rem_sh;
          end
          quo_q <= {quo_q[WordWidth-2:0], 1'b0};
          bit_q <= bit_q - BitCntW'(1);
          if (bit_q == BitCntW'(1)) begin
            state_q <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (rem_q == '0) begin
            prime_q <= 1'b0;
            state_q <= S_DONE;
          end else begin
            // (j+2)^2 = j^2 + 4j + 4
            sq_q    <= sq_q + {{(WordWidth-2){1'b0}}, j_q, 2'b00}
                       + (2*WordWidth)'(4);
            j_q     <= j_q + WordWidth'(2);
            state_q <= S_CHECK;
          end
        end
        S_DONE: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.prime = prime_q;

endmodule

[rtl/core/aise_seq.sv]
// ----------------------------------------------------------------------------
// aise_seq
// Request sequencer: walks the entry store one entry at a time for inserts
// and queries, accumulates results and drives the response register.
// ----------------------------------------------------------------------------
module aise_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  aise_req_if.sink              req,
  aise_rsp_if.source            rsp,
  output logic                  we_o,
  output logic [aise_pkg::IdxW-1:0]      addr_o,
  output logic [aise_pkg::WordWidth-1:0] wdata_o,
  input  logic [aise_pkg::WordWidth-1:0] rdata_i,
  output aise_pkg::prime_req_t  prime_req_o,
  input  aise_pkg::prime_rsp_t  prime_rsp_i
);
  import aise_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ZFILL, S_SH_RD, S_SH_WR, S_PUT, S_SCAN_RD, S_SCAN_WAIT, S_SCAN_USE,
    S_PRIME_WAIT, S_RESP
  } state_e;

  state_e               state_q;
  logic [2:0]           req_q;
  logic [IdxW-1:0]      pos_q;
  logic [WordWidth-1:0] val_q;
  logic [CntW-1:0]      cnt_q;
  logic [CntW-1:0]      idx_q;
  logic [1:0]           status_q;
  logic signed [MainW-1:0]     main_q;
  logic signed [WordWidth-1:0] min_q;
  logic                 rsp_valid_q;
  logic                 we_q;
  logic [IdxW-1:0]      addr_q;
  logic [WordWidth-1:0] wdata_q;
  logic                 pstart_q;
  logic [WordWidth-1:0] pword_q;

  logic signed [WordWidth-1:0] rd_s;
  logic                        pos_ok;
  logic [CntW-1:0]             pos_ext;

  assign rd_s    = signed'(rdata_i);
  assign pos_ok  = (32'(req.payload.position) < Capacity);
  assign pos_ext = CntW'(req.payload.position);

  assign req.ready = (state_q == S_IDLE) && !rsp_valid_q;
  assign rsp.valid = rsp_valid_q;
  assign rsp.payload.status      = status_q;
  assign rsp.payload.result_main = main_q;
  assign rsp.payload.result_min  = ((req_q == REQ_MINMAX) && (status_q == ST_OK))
                                   ? min_q : '0;
  assign rsp.payload.fill_count  = 8'(cnt_q);

  assign we_o    = we_q;
  assign addr_o  = addr_q;
  assign wdata_o = wdata_q;
  assign prime_req_o.start = pstart_q;
  assign prime_req_o.word  = pword_q;

  // main sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
      we_q        <= 1'b0;
      pstart_q    <= 1'b0;
    end else begin
      we_q     <= 1'b0;
      pstart_q <= 1'b0;
      if (rsp_valid_q && rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            req_q    <= req.payload.req_type;
            pos_q    <= IdxW'(req.payload.position);
            val_q    <= req.payload.value;
            status_q <= ST_OK;
            main_q   <= '0;
            min_q    <= '0;
            idx_q    <= '0;
            state_q  <= S_RESP;
            case (req.payload.req_type)
              REQ_APPEND: begin
                if (32'(cnt_q) >= Capacity) begin
                  status_q <= ST_FULL;
                end else begin
                  we_q    <= 1'b1;
                  addr_q  <= IdxW'(cnt_q);
                  wdata_q <= req.payload.value;
                  cnt_q   <= cnt_q + CntW'(1);
                end
              end
              REQ_INSERT: begin
                if (!pos_ok) begin
                  status_q <= ST_BAD_POS;
                end else if (pos_ext >= cnt_q) begin
                  idx_q   <= cnt_q;
                  state_q <= S_ZFILL;
                end else if (32'(cnt_q) >= Capacity) begin
                  status_q <= ST_FULL;
                end else begin
                  idx_q   <= cnt_q;
                  state_q <= S_SH_RD;
                end
              end
              REQ_READ: begin
                if (!pos_ok || pos_ext >= cnt_q) begin
                  status_q <= ST_BAD_POS;
                end else begin
                  addr_q  <= IdxW'(req.payload.position);
                  idx_q   <= cnt_q - CntW'(1);
                  state_q <= S_SCAN_WAIT;
                end
              end
              REQ_EVEN, REQ_PRIME, REQ_COUNT: begin
                if (cnt_q != '0) state_q <= S_SCAN_RD;
              end
              REQ_MINMAX: begin
                if (cnt_q == '0) status_q <= ST_EMPTY;
                else state_q <= S_SCAN_RD;
              end
              default: ;
            endcase
          end
        end
        // zero the gap between count and position
        S_ZFILL: begin
          we_q   <= 1'b1;
          addr_q <= IdxW'(idx_q);
          if (IdxW'(idx_q) == pos_q) begin
            wdata_q <= val_q;
            cnt_q   <= CntW'(pos_q) + CntW'(1);
            state_q <= S_RESP;
          end else begin
            wdata_q <= '0;
            idx_q   <= idx_q + CntW'(1);
          end
        end
        // shift: read entry idx-1
        S_SH_RD: begin
          if (IdxW'(idx_q) == pos_q) begin
            we_q    <= 1'b1;
            addr_q  <= pos_q;
            wdata_q <= val_q;
            cnt_q   <= cnt_q + CntW'(1);
            state_q <= S_RESP;
          end else begin
            addr_q  <= IdxW'(idx_q - CntW'(1));
            state_q <= S_PUT;
          end
        end
        S_PUT: state_q <= S_SH_WR;
        S_SH_WR: begin
          we_q    <= 1'b1;
          addr_q  <= IdxW'(idx_q);
          wdata_q <= rdata_i;
          idx_q   <= idx_q - CntW'(1);
          state_q <= S_SH_RD;
        end
        // scan issue read
        S_SCAN_RD: begin
          addr_q  <= IdxW'(idx_q);
          state_q <= S_SCAN_WAIT;
        end
        // store samples the address, data comes back next cycle
        S_SCAN_WAIT: state_q <= S_SCAN_USE;
        S_SCAN_USE: begin
          state_q <= S_SCAN_RD;
          case (req_q)
            REQ_READ: main_q <= MainW'(rd_s);
            REQ_EVEN: if (!rdata_i[0]) main_q <= main_q + MainW'(rd_s);
            REQ_COUNT: if (rdata_i == val_q) main_q <= main_q + MainW'(1);
            REQ_MINMAX: begin
              if (idx_q == '0) begin
                main_q <= MainW'(rd_s);
                min_q  <= rd_s;
              end else begin
                if (MainW'(rd_s) > main_q) main_q <= MainW'(rd_s);
                if (rd_s < min_q) min_q <= rd_s;
              end
            end
            REQ_PRIME: begin
              pstart_q <= 1'b1;
              pword_q  <= rdata_i;
              state_q  <= S_PRIME_WAIT;
            end
            default: ;
          endcase
          if (req_q != REQ_PRIME) begin
            idx_q <= idx_q + CntW'(1);
            if (req_q == REQ_READ || idx_q + CntW'(1) >= cnt_q) state_q <= S_RESP;
          end
        end
        S_PRIME_WAIT: begin
          if (prime_rsp_i.done) begin
            if (prime_rsp_i.prime) main_q <= main_q + MainW'(signed'(pword_q));
            idx_q <= idx_q + CntW'(1);
            state_q <= (idx_q + CntW'(1) >= cnt_q) ? S_RESP : S_SCAN_RD;
          end
        end
        S_RESP: begin
          rsp_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/array_insert_and_statistics_engine.sv]
// Request transfer to response valid: append, errors and empty queries go
// straight to the response; read waits for one store read; an insert shifts
// or zero-fills entries one at a time; a scan reads every entry in turn.
// Prime sum also waits on the trial divider for each entry.
// Throughput: one request at a time; the next transfer follows the response.
// Reset: fill count cleared, entries left unwritten, no clearing pass.
// ----------------------------------------------------------------------------
// array_insert_and_statistics_engine
// Ordered array store with insert, read and statistics queries.
// ----------------------------------------------------------------------------
module array_insert_and_statistics_engine (
  input  logic       clk_i,
  input  logic       rst_ni,
  aise_req_if.sink   req,
  aise_rsp_if.source rsp
);
  import aise_pkg::*;

  logic                 we;
  logic [IdxW-1:0]      addr;
  logic [WordWidth-1:0] wdata;
  logic [WordWidth-1:0] rdata;
  prime_req_t           prime_req;
  prime_rsp_t           prime_rsp;

  aise_seq u_seq (
    .clk_i, .rst_ni, .req, .rsp,
    .we_o(we), .addr_o(addr), .wdata_o(wdata), .rdata_i(rdata),
    .prime_req_o(prime_req), .prime_rsp_i(prime_rsp)
  );

  aise_ram u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  aise_prime u_prime (
    .clk_i, .rst_ni, .req_i(prime_req), .rsp_o(prime_rsp)
  );

`ifndef NO_ASSERTIONS
  // fill count never exceeds capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> (32'(rsp.payload.fill_count) <= Capacity))
    else $error("fill count over capacity");

  // no new request is taken while a response waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> !req.ready)
    else $error("request taken with response pending");

  // empty status only with zero fill
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && rsp.payload.status == ST_EMPTY) |-> (rsp.payload.fill_count == '0))
    else $error("empty status with entries");
`endif

endmodule
